// File: rtl/salct_pkg.sv
// Shared types and constants for the set-associative LRU cache tracker.
// No dependencies; used by salct_way_unit and set_assoc_lru_cache_tracker.
`timescale 1ns / 1ps
`default_nettype none

package salct_pkg;

  localparam int unsigned MAX_SET_BITS_DEF = 8;
  localparam int unsigned MAX_WAYS_DEF     = 8;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd2;

  localparam logic [3:0] SET_BITS_RST    = 4'd4;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
  localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic hit;
    logic take_empty;
    logic take_lru;
  } way_eval_t;

endpackage

`default_nettype wire

// File: rtl/salct_way_unit.sv
// Shared per-way evaluation: tag match, first empty way and LRU candidate.
// Depends on salct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salct_way_unit (
  input  var salct_pkg::line_t                     line_i,
  input  var logic [salct_pkg::TAG_W-1:0]          tag_i,
  input  var logic                                 have_empty_i,
  input  var logic                                 have_lru_i,
  input  var logic [salct_pkg::STAMP_W-1:0]        lru_stamp_i,
  output salct_pkg::way_eval_t                     eval_o
);

  logic tag_eq;

  assign tag_eq = (line_i.tag == tag_i);

  always_comb begin
    eval_o.hit        = line_i.valid && tag_eq;
    eval_o.take_empty = !line_i.valid && !have_empty_i;
    // strict less: the lower way keeps ties
    eval_o.take_lru   = line_i.valid && !tag_eq &&
                        (!have_lru_i || (line_i.stamp < lru_stamp_i));
  end

endmodule

`default_nettype wire

// File: rtl/set_assoc_lru_cache_tracker.sv
// Top level: set-associative cache tracker with LRU replacement.
// Depends on salct_pkg and salct_way_unit.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | in        | in_valid_i / in_stall_o    | address_i
//  out     | out       | out_valid_o / out_stall_i  | outcome_o, way_used_o, *_total_o
//  cfg     | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// A word passes through ST_PREP, ST_LOOK, ST_SCAN, ST_WRITE and ST_DONE from acceptance to a loaded
// result; ST_SCAN reads one line per cycle from the line memory, up to the hit or ways_in_use.
// After reset the line memory is swept clear, one line a cycle, all 2**MAX_SET_BITS *
// MAX_WAYS lines (2048 by default); in_stall_o stays high meanwhile.
// One word is in work at a time; a finished result waits in the output register
// under out_stall_i while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_tracker #(
  parameter int unsigned MAX_SET_BITS = salct_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = salct_pkg::MAX_WAYS_DEF
) (
  input  var logic                               clk_i,
  input  var logic                               rst_ni,
  input  var logic                               cfg_we_i,
  input  var logic [salct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  var logic [salct_pkg::CFG_W-1:0]        cfg_data_i,
  input  var logic                               in_valid_i,
  output logic                                   in_stall_o,
  input  var logic [salct_pkg::ADDR_W-1:0]       address_i,
  output logic                                   out_valid_o,
  input  var logic                               out_stall_i,
  output logic [1:0]                             outcome_o,
  output logic [2:0]                             way_used_o,
  output logic [salct_pkg::CNT_W-1:0]            hit_total_o,
  output logic [salct_pkg::CNT_W-1:0]            miss_total_o,
  output logic [salct_pkg::CNT_W-1:0]            eviction_total_o
);

  localparam int unsigned NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int unsigned NUM_LINES = NUM_SETS * MAX_WAYS;
  localparam int unsigned LIDX_W    = $clog2(NUM_LINES);
  localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned SB_W      = $clog2(MAX_SET_BITS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [3:0] set_bits_q;
  logic [3:0] ways_in_use_q;
  logic [5:0] block_bits_q;

  // word in work
  logic [salct_pkg::ADDR_W-1:0]  addr_q;
  logic [MAX_SET_BITS-1:0]       set_q;
  logic [salct_pkg::TAG_W-1:0]   tag_q;
  logic [WCNT_W-1:0]             nways_q;
  logic [WCNT_W-1:0]             chk_q;
  logic                          hit_q;
  logic                          have_empty_q;
  logic                          have_lru_q;
  logic [salct_pkg::STAMP_W-1:0] lru_stamp_q;
  logic [WAY_W-1:0]              hit_way_q;
  logic [WAY_W-1:0]              empty_way_q;
  logic [WAY_W-1:0]              lru_way_q;
  logic [WAY_W-1:0]              res_way_q;
  salct_pkg::outcome_e           res_outcome_q;
  logic [LIDX_W-1:0]             clr_idx_q;

  logic [salct_pkg::STAMP_W-1:0] stamp_q;
  logic [salct_pkg::CNT_W-1:0]   hit_cnt_q;
  logic [salct_pkg::CNT_W-1:0]   miss_cnt_q;
  logic [salct_pkg::CNT_W-1:0]   evict_cnt_q;

  // output register
  logic                          out_valid_q;
  logic [1:0]                    outcome_q;
  logic [2:0]                    way_used_q;
  logic [salct_pkg::CNT_W-1:0]   hit_out_q;
  logic [salct_pkg::CNT_W-1:0]   miss_out_q;
  logic [salct_pkg::CNT_W-1:0]   evict_out_q;

  // line memory
  salct_pkg::line_t line_mem [NUM_LINES];
  salct_pkg::line_t rd_line_q;
  logic             mem_we;
  logic [LIDX_W-1:0] mem_widx;
  logic [LIDX_W-1:0] mem_ridx;
  salct_pkg::line_t mem_wline;

  // address split
  logic [SB_W-1:0]               s_eff;
  logic [6:0]                    split_total;
  logic [MAX_SET_BITS-1:0]       idx_mask;
  logic [salct_pkg::ADDR_W-1:0]  addr_sh;
  logic [MAX_SET_BITS-1:0]       set_d;
  logic [salct_pkg::TAG_W-1:0]   tag_d;
  logic [WCNT_W-1:0]             nways_d;

  logic                          accept;
  logic                          last_way;
  logic [WAY_W-1:0]              chk_way;
  logic [WAY_W-1:0]              rd_way;
  logic [WAY_W-1:0]              sel_way;
  salct_pkg::outcome_e           sel_outcome;
  logic [LIDX_W-1:0]             set_base;
  salct_pkg::way_eval_t          eval;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    if (32'(set_bits_q) > MAX_SET_BITS) begin
      s_eff = SB_W'(MAX_SET_BITS);
    end else begin
      s_eff = SB_W'(set_bits_q);
    end
    if (ways_in_use_q == 4'd0) begin
      nways_d = WCNT_W'(1);
    end else if (32'(ways_in_use_q) > MAX_WAYS) begin
      nways_d = WCNT_W'(MAX_WAYS);
    end else begin
      nways_d = WCNT_W'(ways_in_use_q);
    end
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      idx_mask[i] = (i < int'(s_eff));
    end
    split_total = 7'(s_eff) + 7'(block_bits_q);
    addr_sh     = addr_q >> block_bits_q;
    set_d       = addr_sh[MAX_SET_BITS-1:0] & idx_mask;
    // tag is zero once the offset and index cover the whole address
    tag_d       = (split_total >= 7'd64) ? '0 : (addr_q >> split_total);
  end

  assign chk_way  = chk_q[WAY_W-1:0];
  assign last_way = (chk_q == nways_q - WCNT_W'(1));
  assign set_base = LIDX_W'(set_q) * LIDX_W'(MAX_WAYS);

  always_comb begin
    if (state_q == ST_SCAN && !last_way) begin
      rd_way = WAY_W'(chk_q + WCNT_W'(1));
    end else if (state_q == ST_SCAN) begin
      rd_way = chk_way;
    end else begin
      rd_way = '0;
    end
    mem_ridx = set_base + LIDX_W'(rd_way);
  end

  always_comb begin
    priority if (hit_q) begin
      sel_way     = hit_way_q;
      sel_outcome = salct_pkg::OUT_HIT;
    end else if (have_empty_q) begin
      sel_way     = empty_way_q;
      sel_outcome = salct_pkg::OUT_FILL;
    end else begin
      sel_way     = lru_way_q;
      sel_outcome = salct_pkg::OUT_EVICT;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_widx  = clr_idx_q;
    mem_wline = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == ST_WRITE) begin
      mem_we          = 1'b1;
      mem_widx        = set_base + LIDX_W'(sel_way);
      mem_wline.valid = 1'b1;
      mem_wline.tag   = tag_q;
      mem_wline.stamp = stamp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_widx] <= mem_wline;
    end
    rd_line_q <= line_mem[mem_ridx];
  end

  salct_way_unit u_way_unit (
    .line_i       (rd_line_q),
    .tag_i        (tag_q),
    .have_empty_i (have_empty_q),
    .have_lru_i   (have_lru_q),
    .lru_stamp_i  (lru_stamp_q),
    .eval_o       (eval)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      set_bits_q    <= salct_pkg::SET_BITS_RST;
      ways_in_use_q <= salct_pkg::WAYS_IN_USE_RST;
      block_bits_q  <= salct_pkg::BLOCK_BITS_RST;
      addr_q        <= '0;
      set_q         <= '0;
      tag_q         <= '0;
      nways_q       <= WCNT_W'(1);
      chk_q         <= '0;
      hit_q         <= 1'b0;
      have_empty_q  <= 1'b0;
      have_lru_q    <= 1'b0;
      lru_stamp_q   <= '0;
      hit_way_q     <= '0;
      empty_way_q   <= '0;
      lru_way_q     <= '0;
      res_way_q     <= '0;
      res_outcome_q <= salct_pkg::OUT_HIT;
      clr_idx_q     <= '0;
      stamp_q       <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      evict_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      outcome_q     <= '0;
      way_used_q    <= '0;
      hit_out_q     <= '0;
      miss_out_q    <= '0;
      evict_out_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          salct_pkg::REG_SET_BITS:    set_bits_q    <= cfg_data_i[3:0];
          salct_pkg::REG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i[3:0];
          salct_pkg::REG_BLOCK_BITS:  block_bits_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // in ST_DONE the output register is reloaded below
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + LIDX_W'(1);
          if (32'(clr_idx_q) == NUM_LINES - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr_q  <= address_i;
            stamp_q <= stamp_q + 1'b1;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          set_q        <= set_d;
          tag_q        <= tag_d;
          nways_q      <= nways_d;
          chk_q        <= '0;
          hit_q        <= 1'b0;
          have_empty_q <= 1'b0;
          have_lru_q   <= 1'b0;
          state_q      <= ST_LOOK;
        end
        ST_LOOK: begin
          // way 0 read in flight
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (eval.hit) begin
            hit_q     <= 1'b1;
            hit_way_q <= chk_way;
            state_q   <= ST_WRITE;
          end else begin
            if (eval.take_empty) begin
              have_empty_q <= 1'b1;
              empty_way_q  <= chk_way;
            end
            if (eval.take_lru) begin
              have_lru_q  <= 1'b1;
              lru_stamp_q <= rd_line_q.stamp;
              lru_way_q   <= chk_way;
            end
            if (last_way) begin
              state_q <= ST_WRITE;
            end else begin
              chk_q <= chk_q + WCNT_W'(1);
            end
          end
        end
        ST_WRITE: begin
          res_way_q     <= sel_way;
          res_outcome_q <= sel_outcome;
          if (hit_q) begin
            if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
          end else begin
            if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
            if (!have_empty_q && evict_cnt_q != '1) begin
              evict_cnt_q <= evict_cnt_q + 1'b1;
            end
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            outcome_q   <= res_outcome_q;
            way_used_q  <= 3'(res_way_q);
            hit_out_q   <= hit_cnt_q;
            miss_out_q  <= miss_cnt_q;
            evict_out_q <= evict_cnt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign way_used_o       = way_used_q;
  assign hit_total_o      = hit_out_q;
  assign miss_total_o     = miss_out_q;
  assign eviction_total_o = evict_out_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (chk_q < nways_q))
    else $error("scan way beyond ways in use");

  a_write_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (WCNT_W'(sel_way) < nways_q))
    else $error("written way beyond ways in use");

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_cnt_q <= miss_cnt_q)
    else $error("eviction count above miss count");

  a_hit_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q >= $past(hit_cnt_q))
    else $error("hit count went down");

endmodule

`default_nettype wire
